// File: src/egsd_pkg.sv
// Shared types and codes for the Exp-Golomb stream decoder.
package egsd_pkg;

    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned NUM_SLOTS = BYTE_BITS + 1;
    localparam int unsigned SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int unsigned ZC_W = 5;
    localparam int unsigned ACC_W = 31;
    localparam int unsigned VALUE_W = 33;
    localparam int unsigned OUT_DATA_W = ((VALUE_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_LONG  = 2'd2
    } code_status_t;

    typedef struct packed {
        logic              in_suffix;
        logic [ZC_W-1:0]   zero_count;
        logic [ZC_W-1:0]   suffix_left;
        logic [ACC_W-1:0]  suffix_accum;
    } dec_state_t;

    typedef struct packed {
        code_status_t      status;
        logic [ZC_W-1:0]   zero_count;
        logic [ACC_W-1:0]  suffix_accum;
    } result_slot_t;

endpackage

// File: src/exp_golomb_stream_decoder.sv
// Order-0 Exp-Golomb stream decoder: a byte-wide bitstream in, one code per output transfer.
// A byte is registered on its input transfer, then decoded into the result buffer once the
// buffer is free; its results are presented from that buffer, one per output transfer.
// Throughput: one byte per cycle while each byte finishes at most one code and m_tready is high;
// a byte that finishes more codes holds the result buffer, one output transfer per cycle, until its last.
// Reset clears the decoder state, the buffer and signed mode at once.
module exp_golomb_stream_decoder
    import egsd_pkg::*;
#(
    parameter int unsigned MAX_PREFIX = 31
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [BYTE_BITS-1:0]    s_tdata,    // [7:0] stream_byte
    input  logic                    s_tlast,    // final_byte

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,    // [32:0] code_value, [39:33] zero
    output logic [1:0]              m_tuser,    // [1:0] code_status
    output logic                    m_tlast,    // run_end

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data    // signed_mode
);

    logic                   in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0]   in_byte_reg;
    logic                   in_final_reg;
    logic                   signed_mode_reg;
    dec_state_t             state_reg;
    dec_state_t             state_dec;
    result_slot_t           res_reg [NUM_SLOTS];
    result_slot_t           slots_dec [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   valid_dec;
    logic [NUM_SLOTS-1:0]   pending_reg, pending_next;
    logic [NUM_SLOTS-1:0]   sel_onehot;
    logic [SLOT_IDX_W-1:0]  sel_idx;
    logic                   out_xfer;
    logic                   buf_free;
    logic                   load;
    result_slot_t           cur;
    logic [31:0]            code_k;
    logic [31:0]            code_u;
    logic [VALUE_W-1:0]     half_ext;
    logic [VALUE_W-1:0]     value;

    egsd_byte_dec #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_dec (
        .state_in    (state_reg),
        .stream_byte (in_byte_reg),
        .final_byte  (in_final_reg),
        .state_out   (state_dec),
        .slots       (slots_dec),
        .slot_valid  (valid_dec)
    );

    assign cfg_ready = 1'b1;

    // The buffer can take a new byte when it is empty or its last pending result leaves this cycle.
    assign m_tvalid = (pending_reg != '0);
    assign m_tlast  = $onehot(pending_reg);
    assign out_xfer = m_tvalid && m_tready;
    assign buf_free = (pending_reg == '0) || (m_tlast && m_tready);
    assign load     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || load;

    always_comb
    begin
        logic found;
        found = 1'b0;
        sel_idx = '0;
        sel_onehot = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (pending_reg[s] && !found)
            begin
                found = 1'b1;
                sel_idx = SLOT_IDX_W'(s);
                sel_onehot[s] = 1'b1;
            end
        end
    end

    // k = 2^n + suffix is the code number plus one.
    assign cur      = res_reg[sel_idx];
    assign code_k   = (32'd1 << cur.zero_count) | {1'b0, cur.suffix_accum};
    assign code_u   = code_k - 32'd1;
    assign half_ext = {2'b00, code_k[31:1]};

    always_comb
    begin
        if (cur.status != ST_OK)
        begin
            value = '0;
        end
        else if (!signed_mode_reg)
        begin
            value = {1'b0, code_u};
        end
        else if (code_k[0])
        begin
            value = '0 - half_ext;
        end
        else
        begin
            value = half_ext;
        end
    end

    assign m_tdata = {{(OUT_DATA_W-VALUE_W){1'b0}}, value};
    assign m_tuser = cur.status;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end

        pending_next = pending_reg;
        if (load)
        begin
            pending_next = valid_dec;
        end
        else if (out_xfer)
        begin
            pending_next = pending_reg & ~sel_onehot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            pending_reg     <= '0;
            state_reg       <= '0;
            signed_mode_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            pending_reg  <= pending_next;
            if (load)
            begin
                state_reg <= state_dec;
            end
            if (cfg_valid && cfg_ready)
            begin
                signed_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_final_reg <= s_tlast;
        end
        if (load)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                res_reg[s] <= slots_dec[s];
            end
        end
    end

`ifndef ASSERT_OFF
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (valid_dec != '0)) |=> m_tvalid)
        else $error("Decoded results were not presented.");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !m_tlast) |=> m_tvalid)
        else $error("A byte's results stopped before its last one.");

    a_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !buf_free) |=> in_valid_reg)
        else $error("A buffered byte was dropped.");

    a_suffix_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.in_suffix |-> (state_reg.suffix_left != '0))
        else $error("Suffix state with no bits left to read.");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_TRUNC)) |-> m_tlast)
        else $error("Truncation result was not the last of its byte.");
`endif

endmodule

// File: src/egsd_byte_dec.sv
// Combinational decode of one stream byte into per-bit result slots.
module egsd_byte_dec
    import egsd_pkg::*;
#(
    parameter int unsigned MAX_PREFIX = 31
)
(
    input  dec_state_t                  state_in,
    input  logic [BYTE_BITS-1:0]        stream_byte,
    input  logic                        final_byte,
    output dec_state_t                  state_out,
    output result_slot_t                slots [NUM_SLOTS],
    output logic [NUM_SLOTS-1:0]        slot_valid
);

    localparam logic [ZC_W-1:0] PREFIX_LIMIT = ZC_W'(MAX_PREFIX);

    always_comb
    begin
        dec_state_t st;
        logic       bit_in;

        st = state_in;
        slot_valid = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            slots[s] = '{status: ST_OK, zero_count: '0, suffix_accum: '0};
        end

        // Slot i holds the result finished by bit i, counted from the MSB.
        for (int i = 0; i < BYTE_BITS; i++)
        begin
            bit_in = stream_byte[BYTE_BITS-1-i];
            if (!st.in_suffix)
            begin
                if (!bit_in)
                begin
                    if (st.zero_count >= PREFIX_LIMIT)
                    begin
                        slot_valid[i] = 1'b1;
                        slots[i].status = ST_LONG;
                        st = '0;
                    end
                    else
                    begin
                        st.zero_count = st.zero_count + ZC_W'(1);
                    end
                end
                else if (st.zero_count == '0)
                begin
                    slot_valid[i] = 1'b1;
                end
                else
                begin
                    st.in_suffix = 1'b1;
                    st.suffix_left = st.zero_count;
                    st.suffix_accum = '0;
                end
            end
            else
            begin
                st.suffix_accum = {st.suffix_accum[ACC_W-2:0], bit_in};
                st.suffix_left = st.suffix_left - ZC_W'(1);
                if (st.suffix_left == '0)
                begin
                    slot_valid[i] = 1'b1;
                    slots[i].zero_count = st.zero_count;
                    slots[i].suffix_accum = st.suffix_accum;
                    st = '0;
                end
            end
        end

        if (final_byte)
        begin
            if (st.in_suffix || (st.zero_count != '0))
            begin
                slot_valid[NUM_SLOTS-1] = 1'b1;
                slots[NUM_SLOTS-1].status = ST_TRUNC;
            end
            st = '0;
        end

        state_out = st;
    end

endmodule
